// File: sv/sd_spi_block_host_macros.svh
// Assertion macros for the SD SPI host checker.
`ifndef SD_SPI_BLOCK_HOST_MACROS_SVH
`define SD_SPI_BLOCK_HOST_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SDH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sd_spi_block_host check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SDH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sd_spi_block_host check failed");

`endif

// File: sv/sdh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sdh_pkg;

    localparam int BLOCK_BYTES = 512;
    localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int TRAIN_BYTES = 10;

    // Request codes
    localparam logic [1:0] REQ_CARD_BYTE = 2'd0;
    localparam logic [1:0] REQ_INIT      = 2'd1;
    localparam logic [1:0] REQ_READ      = 2'd2;
    localparam logic [1:0] REQ_WRITE     = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_PARAM_ERR   = 3'd1;
    localparam logic [2:0] ST_NOT_READY   = 3'd2;
    localparam logic [2:0] ST_ERROR       = 3'd3;
    localparam logic [2:0] ST_INIT_FAILED = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_READY_LIMIT = 2'd0;
    localparam logic [1:0] CFG_RESP_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_TOKEN_LIMIT = 2'd2;
    localparam logic [1:0] CFG_INIT_LIMIT  = 2'd3;

    // Command numbers
    localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
    localparam logic [5:0] CMD_IF_COND  = 6'd8;
    localparam logic [5:0] CMD_READ     = 6'd17;
    localparam logic [5:0] CMD_WRITE    = 6'd24;
    localparam logic [5:0] CMD_OP_COND  = 6'd41;
    localparam logic [5:0] CMD_APP      = 6'd55;
    localparam logic [5:0] CMD_READ_OCR = 6'd58;

    localparam logic [7:0]  BYTE_IDLE   = 8'hFF;
    localparam logic [7:0]  BYTE_TOKEN  = 8'hFE;
    localparam logic [7:0]  CRC_CMD0    = 8'h95;
    localparam logic [7:0]  CRC_CMD8    = 8'h87;
    localparam logic [7:0]  CRC_DUMMY   = 8'h01;
    localparam logic [7:0]  CMD_START   = 8'h40;
    localparam logic [4:0]  DRESP_MASKED_OK = 5'h05;
    localparam logic [31:0] ARG_IF_COND = 32'h0000_01AA;
    localparam logic [31:0] ARG_HCS     = 32'h4000_0000;

    typedef enum logic [4:0] {
        PH_IDLE, PH_TRAIN, PH_CMD_DESEL, PH_CMD_READY, PH_CMD_FRAME, PH_CMD_RESP,
        PH_CMD_FAIL, PH_R7, PH_OCR, PH_RD_TOKEN, PH_RD_DATA, PH_RD_CRC,
        PH_WR_GAP, PH_WR_DATA, PH_WR_CRC, PH_WR_RESP, PH_WR_BUSY
    } phase_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  drive;
        logic [31:0] sector;
        logic [15:0] sector_count;
        logic [7:0]  miso_byte;
        logic [7:0]  payload_byte;
    } in_item_t;

    typedef struct packed {
        logic       spi_valid;
        logic [7:0] mosi_byte;
        logic       select_low;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       payload_request;
        logic [8:0] payload_index;
        logic       done_res;
        logic [2:0] status;
        logic       high_capacity;
        logic       initialized;
    } result_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  index;
        logic [15:0] data;
    } cfg_write_t;

    // Build a six-byte command frame with its fixed CRC
    function automatic logic [47:0] make_frame(input logic [5:0] cmd, input logic [31:0] arg);
        logic [7:0] crc;
        crc = CRC_DUMMY;
        if (cmd == CMD_GO_IDLE) crc = CRC_CMD0;
        if (cmd == CMD_IF_COND) crc = CRC_CMD8;
        return {CMD_START | {2'b00, cmd}, arg, crc};
    endfunction

endpackage
`default_nettype wire

// File: sv/sdh_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
module sdh_in_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire sdh_pkg::in_item_t in_item,
    input  wire logic              advance,
    output logic                   item_valid,
    output sdh_pkg::in_item_t      item
);
    import sdh_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    // Hold the request while the sequencer cannot take it
    assign in_stall   = valid_reg && !advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg <= in_item;
        end
    end
endmodule
`default_nettype wire

// File: sv/sdh_seq.sv
`timescale 1ns / 1ps
`default_nettype none
module sdh_seq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sdh_pkg::cfg_write_t cfg,
    input  wire logic                fire,
    input  wire sdh_pkg::in_item_t   item,
    output sdh_pkg::result_t         res
);
    import sdh_pkg::*;

    logic [15:0] ready_limit_reg, token_limit_reg, init_limit_reg;
    logic [7:0]  resp_limit_reg;

    phase_t      phase_reg, phase_next;
    logic [47:0] frame_reg, frame_next;
    logic [15:0] retry_reg, retry_next;
    logic [15:0] attempts_reg, attempts_next;
    logic [9:0]  count_reg, count_next;
    logic [15:0] left_reg, left_next;
    logic [31:0] cur_sector_reg, cur_sector_next;
    logic        hc_reg, hc_next;
    logic        ready_reg, ready_next;
    logic        v2_reg, v2_next;
    logic [5:0]  pend_reg, pend_next;
    logic        cs_reg, cs_next;

    logic        do_dispatch, do_acmd, do_start, do_issue;
    logic [7:0]  resp;
    logic [5:0]  issue_cmd;
    logic [31:0] issue_arg;
    logic [31:0] sector_addr;
    logic [9:0]  count_inc;
    logic [5:0]  frame_cmd;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_limit_reg <= 16'd500;
            resp_limit_reg  <= 8'd10;
            token_limit_reg <= 16'd10000;
            init_limit_reg  <= 16'd1000;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_READY_LIMIT: ready_limit_reg <= cfg.data;
                CFG_RESP_LIMIT:  resp_limit_reg  <= cfg.data[7:0];
                CFG_TOKEN_LIMIT: token_limit_reg <= cfg.data;
                default:         init_limit_reg  <= cfg.data;
            endcase
        end
    end

    assign frame_cmd = frame_reg[45:40];
    assign count_inc = count_reg + 10'd1;

    // Compute next state and the result for one item
    always_comb
    begin
        phase_next      = phase_reg;
        frame_next      = frame_reg;
        retry_next      = retry_reg;
        attempts_next   = attempts_reg;
        count_next      = count_reg;
        left_next       = left_reg;
        cur_sector_next = cur_sector_reg;
        hc_next         = hc_reg;
        ready_next      = ready_reg;
        v2_next         = v2_reg;
        pend_next       = pend_reg;
        cs_next         = cs_reg;
        do_dispatch     = 1'b0;
        do_acmd         = 1'b0;
        do_start        = 1'b0;
        do_issue        = 1'b0;
        resp            = BYTE_IDLE;
        issue_cmd       = CMD_GO_IDLE;
        issue_arg       = 32'd0;
        sector_addr     = 32'd0;
        res             = '0;

        if (item.req_type != REQ_CARD_BYTE)
        begin
            // Start a new request, dropping any running sequence
            if (item.drive != 8'd0 ||
                (item.req_type != REQ_INIT && item.sector_count == 16'd0))
            begin
                res.done_res = 1'b1;
                res.status   = ST_PARAM_ERR;
                phase_next   = PH_IDLE;
            end
            else if (item.req_type == REQ_INIT)
            begin
                res.spi_valid = 1'b1;
                res.mosi_byte = BYTE_IDLE;
                cs_next       = 1'b0;
                count_next    = 10'd1;
                phase_next    = PH_TRAIN;
            end
            else if (!ready_reg)
            begin
                res.done_res = 1'b1;
                res.status   = ST_NOT_READY;
                phase_next   = PH_IDLE;
            end
            else
            begin
                left_next       = item.sector_count;
                cur_sector_next = item.sector;
                do_issue        = 1'b1;
                issue_cmd       = (item.req_type == REQ_READ) ? CMD_READ : CMD_WRITE;
                sector_addr     = item.sector;
            end
        end
        else
        begin
            unique case (phase_reg) inside
                PH_TRAIN:
                begin
                    if (count_reg < 10'(TRAIN_BYTES + 1))
                    begin
                        res.spi_valid = 1'b1;
                        res.mosi_byte = BYTE_IDLE;
                        cs_next       = 1'b0;
                        count_next    = count_inc;
                    end
                    else
                    begin
                        do_issue  = 1'b1;
                        issue_cmd = CMD_GO_IDLE;
                    end
                end
                PH_CMD_DESEL:
                begin
                    res.spi_valid = 1'b1;
                    res.mosi_byte = BYTE_IDLE;
                    cs_next       = 1'b1;
                    retry_next    = 16'd1;
                    phase_next    = PH_CMD_READY;
                end
                PH_CMD_READY:
                begin
                    res.spi_valid = 1'b1;
                    if (item.miso_byte == BYTE_IDLE)
                    begin
                        res.mosi_byte = frame_reg[47:40];
                        cs_next       = 1'b1;
                        count_next    = 10'd1;
                        phase_next    = PH_CMD_FRAME;
                    end
                    else if (retry_reg >= ready_limit_reg)
                    begin
                        res.mosi_byte = BYTE_IDLE;
                        cs_next       = 1'b0;
                        phase_next    = PH_CMD_FAIL;
                    end
                    else
                    begin
                        res.mosi_byte = BYTE_IDLE;
                        cs_next       = 1'b1;
                        retry_next    = retry_reg + 16'd1;
                    end
                end
                PH_CMD_FRAME:
                begin
                    res.spi_valid = 1'b1;
                    cs_next       = 1'b1;
                    if (count_reg < 10'd6)
                    begin
                        case (count_reg[2:0])
                            3'd1:    res.mosi_byte = frame_reg[39:32];
                            3'd2:    res.mosi_byte = frame_reg[31:24];
                            3'd3:    res.mosi_byte = frame_reg[23:16];
                            3'd4:    res.mosi_byte = frame_reg[15:8];
                            3'd5:    res.mosi_byte = frame_reg[7:0];
                            default: res.mosi_byte = frame_reg[47:40];
                        endcase
                        count_next = count_inc;
                    end
                    else
                    begin
                        res.mosi_byte = BYTE_IDLE;
                        retry_next    = 16'd1;
                        phase_next    = PH_CMD_RESP;
                    end
                end
                PH_CMD_RESP:
                begin
                    if (!item.miso_byte[7])
                    begin
                        do_dispatch = 1'b1;
                        resp        = item.miso_byte;
                    end
                    else if (retry_reg >= {8'd0, resp_limit_reg})
                    begin
                        do_dispatch = 1'b1;
                    end
                    else
                    begin
                        retry_next    = retry_reg + 16'd1;
                        res.spi_valid = 1'b1;
                        res.mosi_byte = BYTE_IDLE;
                        cs_next       = 1'b1;
                    end
                end
                PH_CMD_FAIL:
                begin
                    do_dispatch = 1'b1;
                end
                PH_R7:
                begin
                    if (count_reg < 10'd4)
                    begin
                        res.spi_valid = 1'b1;
                        res.mosi_byte = BYTE_IDLE;
                        cs_next       = 1'b1;
                        count_next    = count_inc;
                    end
                    else
                    begin
                        do_start = 1'b1;
                    end
                end
                PH_OCR:
                begin
                    if (count_reg == 10'd1)
                    begin
                        hc_next = item.miso_byte[6];
                    end
                    if (count_reg < 10'd4)
                    begin
                        res.spi_valid = 1'b1;
                        res.mosi_byte = BYTE_IDLE;
                        cs_next       = 1'b1;
                        count_next    = count_inc;
                    end
                    else
                    begin
                        ready_next   = 1'b1;
                        res.done_res = 1'b1;
                        res.status   = ST_OK;
                        phase_next   = PH_IDLE;
                    end
                end
                PH_RD_TOKEN:
                begin
                    if (item.miso_byte == BYTE_TOKEN)
                    begin
                        res.spi_valid = 1'b1;
                        res.mosi_byte = BYTE_IDLE;
                        cs_next       = 1'b1;
                        count_next    = 10'd0;
                        phase_next    = PH_RD_DATA;
                    end
                    else if (retry_reg >= token_limit_reg)
                    begin
                        res.done_res = 1'b1;
                        res.status   = ST_ERROR;
                        phase_next   = PH_IDLE;
                    end
                    else
                    begin
                        retry_next    = retry_reg + 16'd1;
                        res.spi_valid = 1'b1;
                        res.mosi_byte = BYTE_IDLE;
                        cs_next       = 1'b1;
                    end
                end
                PH_RD_DATA:
                begin
                    res.read_valid = 1'b1;
                    res.read_byte  = item.miso_byte;
                    res.spi_valid  = 1'b1;
                    res.mosi_byte  = BYTE_IDLE;
                    cs_next        = 1'b1;
                    count_next     = count_inc;
                    if (count_inc >= 10'(BLOCK_BYTES))
                    begin
                        count_next = 10'd1;
                        phase_next = PH_RD_CRC;
                    end
                end
                PH_RD_CRC, PH_WR_BUSY:
                begin
                    if (phase_reg == PH_RD_CRC ? (count_reg < 10'd2)
                                               : (item.miso_byte == 8'd0))
                    begin
                        res.spi_valid = 1'b1;
                        res.mosi_byte = BYTE_IDLE;
                        cs_next       = 1'b1;
                        if (phase_reg == PH_RD_CRC)
                        begin
                            count_next = count_inc;
                        end
                    end
                    else
                    begin
                        // Advance to the next sector or close the request
                        cur_sector_next = cur_sector_reg + 32'd1;
                        left_next       = left_reg - 16'd1;
                        if (left_next == 16'd0)
                        begin
                            res.done_res = 1'b1;
                            res.status   = ST_OK;
                            phase_next   = PH_IDLE;
                        end
                        else
                        begin
                            do_issue    = 1'b1;
                            issue_cmd   = frame_cmd;
                            sector_addr = cur_sector_next;
                        end
                    end
                end
                PH_WR_GAP:
                begin
                    res.spi_valid       = 1'b1;
                    res.mosi_byte       = BYTE_TOKEN;
                    cs_next             = 1'b1;
                    res.payload_request = 1'b1;
                    res.payload_index   = 9'd0;
                    count_next          = 10'd0;
                    phase_next          = PH_WR_DATA;
                end
                PH_WR_DATA:
                begin
                    res.spi_valid = 1'b1;
                    cs_next       = 1'b1;
                    if (count_reg < 10'(BLOCK_BYTES))
                    begin
                        res.mosi_byte = item.payload_byte;
                        count_next    = count_inc;
                        if (count_inc < 10'(BLOCK_BYTES))
                        begin
                            res.payload_request = 1'b1;
                            res.payload_index   = count_inc[8:0];
                        end
                    end
                    else
                    begin
                        res.mosi_byte = BYTE_IDLE;
                        count_next    = 10'd1;
                        phase_next    = PH_WR_CRC;
                    end
                end
                PH_WR_CRC:
                begin
                    res.spi_valid = 1'b1;
                    res.mosi_byte = BYTE_IDLE;
                    cs_next       = 1'b1;
                    if (count_reg < 10'd2)
                    begin
                        count_next = count_inc;
                    end
                    else
                    begin
                        phase_next = PH_WR_RESP;
                    end
                end
                PH_WR_RESP:
                begin
                    if (item.miso_byte[4:0] != DRESP_MASKED_OK)
                    begin
                        res.done_res = 1'b1;
                        res.status   = ST_ERROR;
                        phase_next   = PH_IDLE;
                    end
                    else
                    begin
                        res.spi_valid = 1'b1;
                        res.mosi_byte = BYTE_IDLE;
                        cs_next       = 1'b1;
                        phase_next    = PH_WR_BUSY;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        // Act on a command response
        if (do_dispatch)
        begin
            case (frame_cmd) inside
                CMD_GO_IDLE:
                begin
                    if (resp != 8'd1)
                    begin
                        res.done_res = 1'b1;
                        res.status   = ST_INIT_FAILED;
                        phase_next   = PH_IDLE;
                    end
                    else
                    begin
                        do_issue  = 1'b1;
                        issue_cmd = CMD_IF_COND;
                        issue_arg = ARG_IF_COND;
                    end
                end
                CMD_IF_COND:
                begin
                    attempts_next = 16'd0;
                    if (resp == 8'd1)
                    begin
                        v2_next       = 1'b1;
                        res.spi_valid = 1'b1;
                        res.mosi_byte = BYTE_IDLE;
                        cs_next       = 1'b1;
                        count_next    = 10'd1;
                        phase_next    = PH_R7;
                    end
                    else
                    begin
                        v2_next  = 1'b0;
                        do_start = 1'b1;
                    end
                end
                CMD_APP:
                begin
                    if (resp > 8'd1)
                    begin
                        do_acmd = 1'b1;
                    end
                    else
                    begin
                        do_issue  = 1'b1;
                        issue_cmd = pend_reg;
                        issue_arg = v2_reg ? ARG_HCS : 32'd0;
                    end
                end
                CMD_OP_COND:
                begin
                    do_acmd = 1'b1;
                end
                CMD_READ_OCR, CMD_READ, CMD_WRITE:
                begin
                    if (resp != 8'd0)
                    begin
                        res.done_res = 1'b1;
                        res.status   = (frame_cmd == CMD_READ_OCR) ? ST_INIT_FAILED
                                                                   : ST_ERROR;
                        phase_next   = PH_IDLE;
                    end
                    else
                    begin
                        res.spi_valid = 1'b1;
                        res.mosi_byte = BYTE_IDLE;
                        cs_next       = 1'b1;
                        if (frame_cmd == CMD_READ_OCR)
                        begin
                            count_next = 10'd1;
                            phase_next = PH_OCR;
                        end
                        else if (frame_cmd == CMD_READ)
                        begin
                            retry_next = 16'd1;
                            phase_next = PH_RD_TOKEN;
                        end
                        else
                        begin
                            phase_next = PH_WR_GAP;
                        end
                    end
                end
                default:
                begin
                    res.done_res = 1'b1;
                    res.status   = ST_ERROR;
                    phase_next   = PH_IDLE;
                end
            endcase
        end

        // Count an ACMD41 attempt
        if (do_acmd)
        begin
            attempts_next = attempts_reg + 16'd1;
            if (resp == 8'd0)
            begin
                if (v2_reg)
                begin
                    do_issue  = 1'b1;
                    issue_cmd = CMD_READ_OCR;
                end
                else
                begin
                    hc_next      = 1'b0;
                    ready_next   = 1'b1;
                    res.done_res = 1'b1;
                    res.status   = ST_OK;
                    phase_next   = PH_IDLE;
                end
            end
            else if (attempts_next >= init_limit_reg)
            begin
                res.done_res = 1'b1;
                res.status   = ST_INIT_FAILED;
                phase_next   = PH_IDLE;
            end
            else
            begin
                do_start = 1'b1;
            end
        end

        // Open an app command with CMD55
        if (do_start)
        begin
            pend_next = CMD_OP_COND;
            do_issue  = 1'b1;
            issue_cmd = CMD_APP;
            issue_arg = 32'd0;
        end

        // Load a command frame and send the deselect byte
        if (do_issue)
        begin
            if (issue_cmd == CMD_READ || issue_cmd == CMD_WRITE)
            begin
                issue_arg = hc_reg ? sector_addr : (sector_addr << BLOCK_SHIFT);
            end
            frame_next    = make_frame(issue_cmd, issue_arg);
            res.spi_valid = 1'b1;
            res.mosi_byte = BYTE_IDLE;
            cs_next       = 1'b0;
            phase_next    = PH_CMD_DESEL;
        end

        res.select_low    = cs_next;
        res.high_capacity = hc_next;
        res.initialized   = ready_next;
    end

    // Update sequencer state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            frame_reg      <= '0;
            retry_reg      <= '0;
            attempts_reg   <= '0;
            count_reg      <= '0;
            left_reg       <= '0;
            cur_sector_reg <= '0;
            hc_reg         <= 1'b0;
            ready_reg      <= 1'b0;
            v2_reg         <= 1'b0;
            pend_reg       <= '0;
            cs_reg         <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            frame_reg      <= frame_next;
            retry_reg      <= retry_next;
            attempts_reg   <= attempts_next;
            count_reg      <= count_next;
            left_reg       <= left_next;
            cur_sector_reg <= cur_sector_next;
            hc_reg         <= hc_next;
            ready_reg      <= ready_next;
            v2_reg         <= v2_next;
            pend_reg       <= pend_next;
            cs_reg         <= cs_next;
        end
    end
endmodule
`default_nettype wire

// File: sv/sdh_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
module sdh_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    input  wire sdh_pkg::result_t res_in,
    input  wire logic             out_stall,
    output logic                  advance,
    output logic                  out_valid,
    output sdh_pkg::result_t      res_out
);
    import sdh_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    // Free the slot when empty or when the result is taken
    assign advance   = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign res_out   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_valid)
        begin
            res_reg <= res_in;
        end
    end
endmodule
`default_nettype wire

// File: sv/sd_spi_block_host.sv
// SD card SPI-mode host sequencer, at most one SPI byte exchange per request.
// Each accepted request passes the input register, then the result register.
// Throughput: one request per cycle when unstalled; next-byte decision is combinational.
// Reset (rst_n low, asynchronous): sequencer idle, flags cleared, select high, limits default.
`timescale 1ns / 1ps
`default_nettype none
module sd_spi_block_host (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [7:0]  drive,
    input  wire logic [31:0] sector,
    input  wire logic [15:0] sector_count,
    input  wire logic [7:0]  miso_byte,
    input  wire logic [7:0]  payload_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             spi_valid,
    output logic [7:0]       mosi_byte,
    output logic             select_low,
    output logic             read_valid,
    output logic [7:0]       read_byte,
    output logic             payload_request,
    output logic [8:0]       payload_index,
    output logic             done_res,
    output logic [2:0]       status,
    output logic             high_capacity,
    output logic             initialized
);
    import sdh_pkg::*;

    in_item_t   in_item, item;
    cfg_write_t cfg;
    result_t    res_comb, res_out;
    logic       item_valid, advance;

    assign cfg_ready = 1'b1;
    assign cfg       = '{valid: cfg_valid, index: cfg_index, data: cfg_data};
    assign in_item   = '{req_type: req_type, drive: drive, sector: sector,
                         sector_count: sector_count, miso_byte: miso_byte,
                         payload_byte: payload_byte};

    sdh_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    sdh_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .fire  (item_valid && advance),
        .item  (item),
        .res   (res_comb)
    );

    sdh_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .res_in     (res_comb),
        .out_stall  (out_stall),
        .advance    (advance),
        .out_valid  (out_valid),
        .res_out    (res_out)
    );

    // Drive the result ports
    assign spi_valid       = res_out.spi_valid;
    assign mosi_byte       = res_out.mosi_byte;
    assign select_low      = res_out.select_low;
    assign read_valid      = res_out.read_valid;
    assign read_byte       = res_out.read_byte;
    assign payload_request = res_out.payload_request;
    assign payload_index   = res_out.payload_index;
    assign done_res        = res_out.done_res;
    assign status          = res_out.status;
    assign high_capacity   = res_out.high_capacity;
    assign initialized     = res_out.initialized;
endmodule
`default_nettype wire

// File: sv/sdh_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "sd_spi_block_host_macros.svh"
module sdh_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic       spi_valid,
    input wire logic       select_low,
    input wire logic       read_valid,
    input wire logic       payload_request,
    input wire logic       done_res,
    input wire logic [2:0] status
);
    import sdh_pkg::*;

    // A stalled result stays presented
    `SDH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    // Status is zero except on the closing result
    `SDH_ASSERT_NOW(a_status_done, out_valid && !done_res, status == ST_OK)
    // Read data arrives only during a selected exchange
    `SDH_ASSERT_NOW(a_read_exch, out_valid && read_valid, spi_valid && select_low)
    // A write-byte request comes with an exchange and never closes the request
    `SDH_ASSERT_NOW(a_payload_exch, out_valid && payload_request, spi_valid && !done_res)
endmodule

bind sd_spi_block_host sdh_checker u_sdh_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .spi_valid       (spi_valid),
    .select_low      (select_low),
    .read_valid      (read_valid),
    .payload_request (payload_request),
    .done_res        (done_res),
    .status          (status)
);
`default_nettype wire
